// ===== rtl/core/lph_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lph_pkg - shared types and codes for the linear probing hash table
// Operation and status codes, register indexes, fixed field widths and the
// sequencer state type.
// ============================================================================
package lph_pkg;

    // fixed field widths
    localparam int OP_BITS     = 2;
    localparam int STAT_BITS   = 2;
    localparam int CNT_BITS    = 8;   // probes, stored probe count, entry count
    localparam int SLOT_BITS   = 7;
    localparam int CFG_BITS    = 8;
    localparam int CFG_ADDR_BITS = 2;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TABLE_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HASH_MODULUS = 2'd1;

    // configuration reset values
    localparam logic [CFG_BITS-1:0] TABLE_SIZE_RST  = 8'd128;
    localparam logic [CFG_BITS-1:0] HASH_MODULUS_RST = 8'd127;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,   // post-reset sweep of the slot memory
        S_IDLE,
        S_HASH,    // home slot: key mod modulus
        S_RD,      // probe read issued
        S_CHK,     // probe word back from memory
        S_DRD,     // delete: read next candidate synonym
        S_DCHK,    // delete: candidate word back
        S_DMOD,    // delete: candidate home slot
        S_DCLR,    // delete: clear last moved-from slot
        S_DONE     // result beat on the ports
    } t_state;

endpackage

// ===== rtl/core/lph_mod_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lph_mod_unit - iterative remainder unit
// Restoring division, one dividend bit per cycle. Gives dividend mod divisor
// on o_rem, with a one-cycle done pulse.
// ============================================================================
module lph_mod_unit #(
    parameter int KEY_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [KEY_BITS-1:0]          i_dividend,
    input  logic [lph_pkg::CNT_BITS-1:0] i_divisor,
    output logic                         o_done,
    output logic [lph_pkg::CNT_BITS-1:0] o_rem
);
    import lph_pkg::*;

    localparam int STEP_BITS = $clog2(KEY_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [KEY_BITS-1:0]   r_dvd;
    logic [CNT_BITS-1:0]   r_div;
    logic [CNT_BITS-1:0]   r_rem;
    logic [CNT_BITS:0]     trial;
    logic [CNT_BITS:0]     n_rem;

    // one restoring step: shift in next bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[KEY_BITS-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // done pulse follows the last step
            r_done <= !i_start && r_busy && (r_step == STEP_BITS'(KEY_BITS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_BITS'(1);
                if (r_step == STEP_BITS'(KEY_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_BITS-2:0], 1'b0};
            r_rem <= n_rem[CNT_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/lph_slot_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lph_slot_ram - slot memory
// One write port, one read port, registered read data.
// Each word holds valid flag, recorded probe count and key.
// ============================================================================
module lph_slot_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// linear_probe_hash_table_core - open-addressing hash table, linear probing
// Insert, search and delete of keys in a slot memory, with a sequencer that
// reads, checks and writes back one slot at a time.
// ============================================================================
// Usage:
//   Command beat: drive i_op / i_key with start high; it is taken on an edge
//   where busy is low. busy stays high until the result beat is gone.
//   Result beat: o_done is high for exactly one cycle with o_status,
//   o_probes, o_slot, o_stored_probes and o_entry_count. The receiver
//   cannot stall; the result must be taken in that cycle.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_addr (0 table
//   size, 1 hash modulus) at once; write only while busy is low.
// Sequence:
//   each probe is a memory read plus a check; the home slot comes
//   from the bit-serial remainder unit.
//   delete hit: adds a synonym shift, each candidate needing its own
//   remainder.
//   Unknown op: no remainder or probe, straight to the result beat.
// Reset: a clearing pass writes every memory word with busy high;
//   config writes are taken during it.
// ============================================================================
module linear_probe_hash_table_core #(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [lph_pkg::OP_BITS-1:0]       i_op,
    input  logic [KEY_BITS-1:0]               i_key,
    // result channel
    output logic                              o_done,
    output logic [lph_pkg::STAT_BITS-1:0]     o_status,
    output logic [lph_pkg::CNT_BITS-1:0]      o_probes,
    output logic [lph_pkg::SLOT_BITS-1:0]     o_slot,
    output logic [lph_pkg::CNT_BITS-1:0]      o_stored_probes,
    output logic [lph_pkg::CNT_BITS-1:0]      o_entry_count,
    // config port
    input  logic                              i_cfg_we,
    input  logic [lph_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [lph_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import lph_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW > CNT_BITS) ? AW : CNT_BITS;
    localparam int WW = 1 + CNT_BITS + KEY_BITS;
    localparam logic [CNT_BITS-1:0] DEPTH_CAP =
        (TABLE_DEPTH > 255) ? 8'd255 : CNT_BITS'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [CFG_BITS-1:0]   r_table_size, r_hash_mod;
    logic [AW-1:0]         r_clr, n_clr;
    logic [OP_BITS-1:0]    r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_prev, n_prev;
    logic [AW-1:0]         r_adr, n_adr;
    logic [CNT_BITS-1:0]   r_home, n_home;
    logic [CNT_BITS-1:0]   r_i, n_i;
    logic [CNT_BITS-1:0]   r_moves, n_moves;
    logic [WW-2:0]         r_word, n_word;
    logic [CNT_BITS-1:0]   r_total, n_total;
    logic [STAT_BITS-1:0]  r_status, n_status;
    logic [CNT_BITS-1:0]   r_probes, n_probes;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic [CNT_BITS-1:0]   r_stored, n_stored;

    // memory and remainder unit hookup
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [WW-1:0]         mem_rd_data;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [WW-1:0]         mem_wr_data;
    logic                  div_start;
    logic [KEY_BITS-1:0]   div_dvd;
    logic                  div_done;
    logic [CNT_BITS-1:0]   div_rem;

    // effective size and modulus
    logic [CNT_BITS-1:0]   size_eff;
    logic [CNT_BITS-1:0]   mod_eff;

    // fields of the word read back
    logic                  rd_valid;
    logic [CNT_BITS-1:0]   rd_pc;
    logic [KEY_BITS-1:0]   rd_key;
    logic [CNT_BITS:0]     moves_next;

    assign rd_valid = mem_rd_data[WW-1];
    assign rd_pc    = mem_rd_data[KEY_BITS +: CNT_BITS];
    assign rd_key   = mem_rd_data[KEY_BITS-1:0];

    // next probe address, wrapping at the effective size
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a,
                                               input logic [CNT_BITS-1:0] sz);
        logic [CW-1:0] nx;
        begin
            nx = CW'(a) + CW'(1);
            wrap_inc = (nx == CW'(sz)) ? '0 : AW'(nx);
        end
    endfunction

    // ------------------------------------------------------------------
    // config registers and clamping
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
            r_hash_mod   <= HASH_MODULUS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_TABLE_SIZE) begin
                r_table_size <= i_cfg_data;
            end else if (i_cfg_addr == CFG_HASH_MODULUS) begin
                r_hash_mod <= i_cfg_data;
            end
        end
    end

    always_comb begin
        size_eff = (r_table_size == '0) ? CNT_BITS'(1) : r_table_size;
        if (size_eff > DEPTH_CAP) begin
            size_eff = DEPTH_CAP;
        end
        mod_eff = (r_hash_mod == '0) ? CNT_BITS'(1) : r_hash_mod;
        if (mod_eff > size_eff) begin
            mod_eff = size_eff;
        end
    end

    // ------------------------------------------------------------------
    // sub-units
    // ------------------------------------------------------------------
    lph_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    lph_mod_unit #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (mod_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // ------------------------------------------------------------------
    // state and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_addr   <= n_addr;
        r_prev   <= n_prev;
        r_adr    <= n_adr;
        r_home   <= n_home;
        r_i      <= n_i;
        r_moves  <= n_moves;
        r_word   <= n_word;
        r_status <= n_status;
        r_probes <= n_probes;
        r_slot   <= n_slot;
        r_stored <= n_stored;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_op     = r_op;
        n_key    = r_key;
        n_addr   = r_addr;
        n_prev   = r_prev;
        n_adr    = r_adr;
        n_home   = r_home;
        n_i      = r_i;
        n_moves  = r_moves;
        n_word   = r_word;
        n_total  = r_total;
        n_status = r_status;
        n_probes = r_probes;
        n_slot   = r_slot;
        n_stored = r_stored;

        mem_rd_en   = 1'b0;
        mem_rd_addr = r_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_prev;
        mem_wr_data = '0;
        div_start   = 1'b0;
        div_dvd     = r_key;
        moves_next  = {1'b0, r_moves} + (CNT_BITS+1)'(1);

        unique case (r_state)
            // zero every word, one per cycle
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_op  = i_op;
                    n_key = i_key;
                    if (i_op == OP_INSERT || i_op == OP_SEARCH || i_op == OP_DELETE) begin
                        div_start = 1'b1;
                        div_dvd   = i_key;
                        n_state   = S_HASH;
                    end else begin
                        n_status = ST_NOTFOUND;
                        n_probes = '0;
                        n_slot   = '0;
                        n_stored = '0;
                        n_state  = S_DONE;
                    end
                end
            end

            S_HASH: begin
                if (div_done) begin
                    n_addr  = AW'(div_rem);
                    n_home  = div_rem;
                    n_i     = CNT_BITS'(1);
                    n_state = S_RD;
                end
            end

            S_RD: begin
                mem_rd_en = 1'b1;
                n_state   = S_CHK;
            end

            // probe check
            S_CHK: begin
                n_status = ST_NOTFOUND;
                n_probes = r_i;
                n_slot   = '0;
                n_stored = '0;
                if (r_op == OP_INSERT) begin
                    if (!rd_valid) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_addr;
                        mem_wr_data = {1'b1, r_i, r_key};
                        if (r_total != '1) begin
                            n_total = r_total + CNT_BITS'(1);
                        end
                        n_status = ST_OK;
                        n_slot   = SLOT_BITS'(r_addr);
                        n_stored = r_i;
                        n_state  = S_DONE;
                    end else if (r_i == size_eff) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_addr  = wrap_inc(r_addr, size_eff);
                        n_i     = r_i + CNT_BITS'(1);
                        n_state = S_RD;
                    end
                end else begin
                    if (!rd_valid) begin
                        n_state = S_DONE;
                    end else if (rd_key == r_key) begin
                        if (r_op == OP_SEARCH) begin
                            n_status = ST_OK;
                            n_slot   = SLOT_BITS'(r_addr);
                            n_stored = rd_pc;
                            n_state  = S_DONE;
                        end else begin
                            n_adr   = r_addr;
                            n_prev  = r_addr;
                            n_addr  = wrap_inc(r_addr, size_eff);
                            n_moves = '0;
                            n_state = (size_eff > CNT_BITS'(1)) ? S_DRD : S_DCLR;
                        end
                    end else if (r_i == size_eff) begin
                        n_state = S_DONE;
                    end else begin
                        n_addr  = wrap_inc(r_addr, size_eff);
                        n_i     = r_i + CNT_BITS'(1);
                        n_state = S_RD;
                    end
                end
            end

            S_DRD: begin
                mem_rd_en = 1'b1;
                n_state   = S_DCHK;
            end

            // candidate synonym: empty ends the run
            S_DCHK: begin
                if (!rd_valid) begin
                    n_state = S_DCLR;
                end else begin
                    n_word    = mem_rd_data[WW-2:0];
                    div_start = 1'b1;
                    div_dvd   = rd_key;
                    n_state   = S_DMOD;
                end
            end

            // same home slot: move it back one place
            S_DMOD: begin
                if (div_done) begin
                    if (div_rem == r_home) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_prev;
                        mem_wr_data = {1'b1, r_word};
                        n_prev      = r_addr;
                        n_addr      = wrap_inc(r_addr, size_eff);
                        n_moves     = moves_next[CNT_BITS-1:0];
                        if (moves_next + (CNT_BITS+1)'(1) < {1'b0, size_eff}) begin
                            n_state = S_DRD;
                        end else begin
                            n_state = S_DCLR;
                        end
                    end else begin
                        n_state = S_DCLR;
                    end
                end
            end

            S_DCLR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_prev;
                mem_wr_data = '0;
                if (r_total != '0) begin
                    n_total = r_total - CNT_BITS'(1);
                end
                n_status = ST_OK;
                n_slot   = SLOT_BITS'(r_adr);
                n_stored = '0;
                n_state  = S_DONE;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign busy            = (r_state != S_IDLE);
    assign o_done          = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_probes        = r_probes;
    assign o_slot          = r_slot;
    assign o_stored_probes = r_stored;
    assign o_entry_count   = r_total;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but busy not raised");

    // memory is never written while idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_wr_en)
        else $error("slot memory written while idle");

    // misses and full answers carry no slot or stored count
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_NOTFOUND || o_status == ST_FULL))
            |-> (o_slot == '0 && o_stored_probes == '0))
        else $error("miss result with nonzero slot or stored count");

    // entry count moves by at most one per operation
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_total != $past(r_total)) |->
            (r_total == $past(r_total) + CNT_BITS'(1) ||
             r_total == $past(r_total) - CNT_BITS'(1)))
        else $error("entry count jumped");

    // remainder result stays below the modulus
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (div_rem < mod_eff))
        else $error("remainder not below modulus");
`endif

endmodule

// ===== bench/tb_linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_linear_probe_hash_table_core - testbench for the linear probing table
// Commands go in one beat at a time. A local copy of the table predicts the
// result beat of each command, and every result beat is compared with it
// field by field. The run covers a directed pass over the corner cases, a
// pass that fills the whole depth with synonyms, and random phases with
// changing table size and modulus and random idle gaps.
// ============================================================================
module tb_linear_probe_hash_table_core;
    import lph_pkg::*;

    localparam int DEPTH = 128;
    localparam int KEY_W = 16;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;   // no such operation
    localparam int POOL_MAX = 48;
    localparam int SHOW_MAX = 10;

    // one result beat
    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [CNT_BITS-1:0]  probes;
        logic [SLOT_BITS-1:0] slot;
        logic [CNT_BITS-1:0]  stored;
        logic [CNT_BITS-1:0]  count;
    } t_reply;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_BITS-1:0]       i_op = '0;
    logic [KEY_W-1:0]         i_key = '0;
    logic                     o_done;
    logic [STAT_BITS-1:0]     o_status;
    logic [CNT_BITS-1:0]      o_probes;
    logic [SLOT_BITS-1:0]     o_slot;
    logic [CNT_BITS-1:0]      o_stored_probes;
    logic [CNT_BITS-1:0]      o_entry_count;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_BITS-1:0]      i_cfg_data = '0;

    // local copy of the table and its registers
    logic [KEY_W-1:0] tbl_key   [DEPTH];
    bit               tbl_used  [DEPTH];
    int unsigned      tbl_probe [DEPTH];
    int unsigned      keys_held = 0;
    logic [CFG_BITS-1:0] size_reg = TABLE_SIZE_RST;
    logic [CFG_BITS-1:0] mod_reg  = HASH_MODULUS_RST;

    t_reply           pending_replies[$];
    logic [KEY_W-1:0] key_pool[$];
    bit               gaps_on = 1'b1;
    int unsigned      n_fail = 0;

    linear_probe_hash_table_core #(
        .TABLE_DEPTH (DEPTH),
        .KEY_BITS    (KEY_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_key           (i_key),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_probes        (o_probes),
        .o_slot          (o_slot),
        .o_stored_probes (o_stored_probes),
        .o_entry_count   (o_entry_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------
    function automatic logic [CNT_BITS-1:0] sat_count(input int unsigned v);
        return (v > 255) ? 8'd255 : CNT_BITS'(v);
    endfunction

    // size 0 acts as 1, above the depth as the depth
    function automatic int unsigned eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > DEPTH) return DEPTH;
        return size_reg;
    endfunction

    function automatic int unsigned eff_modulus();
        int unsigned m;
        m = (mod_reg == 0) ? 1 : mod_reg;
        if (m > eff_size()) m = eff_size();
        return m;
    endfunction

    // bounded probe run: stops at an empty slot, the key, or after size probes
    function automatic bit find_key(input logic [KEY_W-1:0] key, input int unsigned size,
                                    input int unsigned modv, output int unsigned cnt,
                                    output int unsigned adr);
        int unsigned a;
        int unsigned n;
        bit hit;
        bit stop;
        a = key % modv;
        cnt = size;
        adr = 0;
        hit = 1'b0;
        stop = 1'b0;
        for (n = 1; n <= size && !stop; n++) begin
            if (!tbl_used[a]) begin
                cnt = n;
                stop = 1'b1;
            end else if (tbl_key[a] == key) begin
                cnt = n;
                adr = a;
                hit = 1'b1;
                stop = 1'b1;
            end else begin
                a = (a + 1) % size;
            end
        end
        return hit;
    endfunction

    // applies one command to the local table and returns its result beat
    function automatic t_reply apply_op(input logic [OP_BITS-1:0] op,
                                        input logic [KEY_W-1:0] key);
        int unsigned size;
        int unsigned modv;
        int unsigned home;
        int unsigned a;
        int unsigned n;
        int unsigned cnt;
        int unsigned adr;
        int unsigned prev;
        int unsigned j;
        int unsigned moves;
        bit placed;
        t_reply r;
        size = eff_size();
        modv = eff_modulus();
        home = key % modv;
        r = '0;
        r.status = ST_NOTFOUND;
        case (op)
            OP_INSERT: begin
                r.status = ST_FULL;
                r.probes = sat_count(size);
                a = home;
                placed = 1'b0;
                for (n = 1; n <= size && !placed; n++) begin
                    if (!tbl_used[a]) begin
                        tbl_used[a] = 1'b1;
                        tbl_key[a] = key;
                        tbl_probe[a] = n;
                        if (keys_held < 255) keys_held++;
                        r.status = ST_OK;
                        r.probes = sat_count(n);
                        r.slot = SLOT_BITS'(a);
                        r.stored = sat_count(n);
                        placed = 1'b1;
                    end else begin
                        a = (a + 1) % size;
                    end
                end
            end
            OP_SEARCH: begin
                if (find_key(key, size, modv, cnt, adr)) begin
                    r.status = ST_OK;
                    r.slot = SLOT_BITS'(adr);
                    r.stored = sat_count(tbl_probe[adr]);
                end
                r.probes = sat_count(cnt);
            end
            OP_DELETE: begin
                if (find_key(key, size, modv, cnt, adr)) begin
                    // pull following synonyms back one place, at most size-1 moves
                    prev = adr;
                    j = (adr + 1) % size;
                    moves = 0;
                    while (moves + 1 < size && tbl_used[j] && (tbl_key[j] % modv) == home) begin
                        tbl_key[prev] = tbl_key[j];
                        tbl_probe[prev] = tbl_probe[j];
                        prev = j;
                        j = (j + 1) % size;
                        moves++;
                    end
                    tbl_used[prev] = 1'b0;
                    tbl_key[prev] = '0;
                    tbl_probe[prev] = 0;
                    if (keys_held > 0) keys_held--;
                    r.status = ST_OK;
                    r.slot = SLOT_BITS'(adr);
                end
                r.probes = sat_count(cnt);
            end
            default: ;
        endcase
        r.count = sat_count(keys_held);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        n_fail++;
        if (n_fail <= SHOW_MAX) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : check_results
        t_reply want;
        t_reply got;
        if (i_rst_n && o_done === 1'b1) begin
            got = {o_status, o_probes, o_slot, o_stored_probes, o_entry_count};
            if (pending_replies.size() == 0) begin
                note_failure($sformatf("result beat with none expected: %p", got));
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    note_failure($sformatf("status: expected %0d, got %0d",
                                           want.status, got.status));
                if (got.probes !== want.probes)
                    note_failure($sformatf("probes: expected %0d, got %0d",
                                           want.probes, got.probes));
                if (got.slot !== want.slot)
                    note_failure($sformatf("slot: expected %0d, got %0d",
                                           want.slot, got.slot));
                if (got.stored !== want.stored)
                    note_failure($sformatf("stored_probes: expected %0d, got %0d",
                                           want.stored, got.stored));
                if (got.count !== want.count)
                    note_failure($sformatf("entry_count: expected %0d, got %0d",
                                           want.count, got.count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    // one command beat; returns just after the edge that took it
    task automatic send_cmd(input logic [OP_BITS-1:0] op, input logic [KEY_W-1:0] key);
        while (gaps_on && $urandom_range(0, 99) < 38) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        do @(posedge i_clk); while (busy);
        pending_replies.push_back(apply_op(op, key));
        if (op == OP_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
        end
    endtask

    // drop start and wait for all results and a quiet block
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0 || busy);
    endtask

    task automatic cfg_phase(input logic [CFG_BITS-1:0] size_val,
                             input logic [CFG_BITS-1:0] mod_val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_TABLE_SIZE;
        i_cfg_data <= size_val;
        @(posedge i_clk);
        size_reg = size_val;
        i_cfg_addr <= CFG_HASH_MODULUS;
        i_cfg_data <= mod_val;
        @(posedge i_clk);
        mod_reg = mod_val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly keys already seen or synonyms of low home slots, some fully random
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        int unsigned m;
        sel = $urandom_range(0, 9);
        m = eff_modulus();
        if (sel < 4 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (sel < 8)
            return KEY_W'($urandom_range(0, 2) + m * $urandom_range(0, 65532 / m));
        return KEY_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // corner cases, starting from the reset registers (size 128, modulus 127)
    task automatic test_directed();
        send_cmd(OP_INSERT, 16'h0000);
        send_cmd(OP_INSERT, 16'hFFFF);
        send_cmd(OP_INSERT, 16'd127);      // synonym of key 0, second probe
        send_cmd(OP_SEARCH, 16'd127);
        send_cmd(OP_SEARCH, 16'd254);      // miss at the end of the run
        send_cmd(OP_UNUSED, 16'hFFFF);
        send_cmd(OP_DELETE, 16'h0000);     // pulls key 127 back to its home
        send_cmd(OP_SEARCH, 16'd127);
        send_cmd(OP_DELETE, 16'h1234);     // delete miss
        // small table, modulus 0 acts as 1; key 0xFFFF sits beyond the size
        cfg_phase(8'd3, 8'd0);
        send_cmd(OP_INSERT, 16'hAAAA);
        send_cmd(OP_INSERT, 16'h5555);
        send_cmd(OP_INSERT, 16'd7);        // table full
        send_cmd(OP_SEARCH, 16'd9);        // search stops after size probes
        send_cmd(OP_DELETE, 16'd9);
        send_cmd(OP_DELETE, 16'd127);      // whole table is one synonym run
        // size 0 acts as 1, modulus above size
        cfg_phase(8'd0, 8'd255);
        send_cmd(OP_INSERT, 16'd1);
        send_cmd(OP_DELETE, 16'hAAAA);
        // size above depth acts as depth; probing wraps past the last slot
        cfg_phase(8'd255, 8'd128);
        send_cmd(OP_INSERT, 16'hFFFF);
        send_cmd(OP_INSERT, 16'h7F7F);
        send_cmd(OP_SEARCH, 16'h7F7F);
        send_cmd(OP_DELETE, 16'hFFFF);     // shift across the wrap
        send_cmd(OP_SEARCH, 16'h7F7F);
    endtask

    // every key a synonym: fill the whole depth, then search and delete in it
    task automatic test_full_depth();
        cfg_phase(8'd128, 8'd1);
        gaps_on = 1'b0;
        repeat (132) send_cmd(OP_INSERT, KEY_W'($urandom));
        gaps_on = 1'b1;
        repeat (8) send_cmd(OP_SEARCH, pick_key());
        repeat (12) send_cmd(OP_DELETE, pick_key());
        repeat (6) send_cmd(OP_INSERT, pick_key());
    endtask

    task automatic test_random_mix();
        logic [CFG_BITS-1:0] size_val;
        logic [CFG_BITS-1:0] mod_val;
        logic [OP_BITS-1:0]  op;
        int unsigned ins_pct;
        int unsigned roll;
        int unsigned phase;
        for (phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 7))
                0: size_val = 8'd0;
                1: size_val = 8'd255;
                2: size_val = 8'd128;
                default: size_val = CFG_BITS'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 5))
                0: mod_val = 8'd0;
                1: mod_val = 8'd1;
                2: mod_val = 8'd255;
                default: mod_val = CFG_BITS'($urandom_range(1, 40));
            endcase
            cfg_phase(size_val, mod_val);
            gaps_on = (phase != 3);
            ins_pct = $urandom_range(25, 60);
            repeat (110) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) op = OP_UNUSED;
                else if (roll < ins_pct) op = OP_INSERT;
                else if (roll < ins_pct + (100 - ins_pct) / 2) op = OP_SEARCH;
                else op = OP_DELETE;
                send_cmd(op, pick_key());
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (tbl_used[i]) begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_probe[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_depth();
        test_random_mix();
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (pending_replies.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_replies.size()));
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #(64'd200_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
